// ===== rtl/fhcd_pkg.sv =====
// Shared types and constants for the frame header check decoder.
package fhcd_pkg;

	// Width of the in-frame byte counter (16 to 32 bits)
	localparam int COUNT_WIDTH = 32;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	// Saturation value of the byte counter
	localparam count_t COUNT_TOP = {COUNT_WIDTH{1'b1}};

	// Header bytes and size
	localparam logic [7:0] HDR_MAGIC0  = 8'h46;
	localparam logic [7:0] HDR_MAGIC1  = 8'h43;
	localparam logic [7:0] HDR_VERSION = 8'h01;
	localparam int         HDR_SIZE    = 10;

	// Header byte offsets
	localparam count_t POS_MAGIC0  = count_t'(0);
	localparam count_t POS_MAGIC1  = count_t'(1);
	localparam count_t POS_VERSION = count_t'(2);
	localparam count_t POS_OP      = count_t'(3);
	localparam count_t POS_TAG_HI  = count_t'(4);
	localparam count_t POS_TAG_LO  = count_t'(5);
	localparam count_t POS_LEN_B3  = count_t'(6);
	localparam count_t POS_LEN_B2  = count_t'(7);
	localparam count_t POS_LEN_B1  = count_t'(8);
	localparam count_t POS_LEN_B0  = count_t'(9);

	// Width used for the length compare: one bit above both operands
	localparam int LEN_W = 33;

	// Input word: one frame byte plus end marker
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	// Result word: one per frame
	typedef struct packed {
		logic        frame_ok;
		logic [7:0]  op_code;
		logic [15:0] request_tag;
		logic [31:0] payload_bytes;
	} out_word_t;

endpackage

// ===== rtl/fhcd_if.sv =====
// Valid/ready stream interfaces for frame bytes and frame results.
interface fhcd_in_if import fhcd_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface fhcd_out_if import fhcd_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/frame_header_check_decoder.sv =====
// Frame header check decoder: byte stream in, one check result per frame out.
//
// Usage:
//   bytes   - sink channel, one frame byte per word with last_byte on the
//             final byte of each frame. A word is taken when valid and ready
//             are both high at a rising clock edge.
//   results - source channel, one word per frame: frame_ok and, when the
//             frame is good, op code, request tag and payload length.
// Throughput: one byte word per cycle while no finished word is held back
//   by results.ready low. The header capture, byte counter step and length
//   compare are all combinational between the held frame state and the result register.
// Latency: the result word is valid the cycle after its last byte is taken.
// Stall: the result register holds a finished word while results.ready is
//   low; a new byte is still taken whenever the result register is empty or
//   is being emptied in the same cycle, so bytes.ready = !valid || ready.
// Reset: arst_n low clears the byte counter and captured header, marks the
//   header good and empties the result register; the next byte starts a
//   new frame. The frame state is cleared the same way after every last byte.
module frame_header_check_decoder
	import fhcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	fhcd_in_if.sink    bytes,
	fhcd_out_if.source results
);

	// Frame state
	count_t      count_q;
	logic        good_q;
	logic [7:0]  op_q;
	logic [15:0] tag_q;
	logic [31:0] len_q;

	// Result register
	logic      out_valid_q;
	out_word_t out_word_q;

	logic        acc;
	logic        ovf;
	logic        good_n;
	logic [7:0]  op_n;
	logic [15:0] tag_n;
	logic [31:0] len_n;
	logic [7:0]  b;
	logic        ok;
	logic [LEN_W-1:0] seen_len;
	logic [LEN_W-1:0] want_len;

	assign bytes.ready = !out_valid_q || results.ready;
	assign acc         = bytes.valid && bytes.ready;
	assign b           = bytes.data.data_byte;
	assign ovf         = (count_q == COUNT_TOP);

	// Header capture at the current offset
	always_comb begin
		good_n = good_q;
		op_n   = op_q;
		tag_n  = tag_q;
		len_n  = len_q;
		case (count_q)
			POS_MAGIC0:  if (b != HDR_MAGIC0) good_n = 1'b0;
			POS_MAGIC1:  if (b != HDR_MAGIC1) good_n = 1'b0;
			POS_VERSION: if (b != HDR_VERSION) good_n = 1'b0;
			POS_OP:      op_n = b;
			POS_TAG_HI:  tag_n[15:8] = b;
			POS_TAG_LO:  tag_n[7:0] = b;
			POS_LEN_B3:  len_n[31:24] = b;
			POS_LEN_B2:  len_n[23:16] = b;
			POS_LEN_B1:  len_n[15:8] = b;
			POS_LEN_B0:  len_n[7:0] = b;
			default:     ;
		endcase
	end

	// Length check: payload length plus header size against frame length, no wrap
	assign seen_len = LEN_W'(count_q) + LEN_W'(1);
	assign want_len = LEN_W'(len_n) + LEN_W'(HDR_SIZE);
	assign ok = !ovf && good_n && (count_q >= POS_LEN_B0) && (want_len == seen_len);

	// Frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			good_q  <= 1'b1;
			op_q    <= '0;
			tag_q   <= '0;
			len_q   <= '0;
		end else if (acc) begin
			if (bytes.data.last_byte) begin
				count_q <= '0;
				good_q  <= 1'b1;
				op_q    <= '0;
				tag_q   <= '0;
				len_q   <= '0;
			end else begin
				if (!ovf) count_q <= count_q + count_t'(1);
				good_q <= good_n;
				op_q   <= op_n;
				tag_q  <= tag_n;
				len_q  <= len_n;
			end
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && bytes.data.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word, fields zeroed for a bad frame
	always_ff @(posedge clk) begin
		if (acc && bytes.data.last_byte) begin
			out_word_q.frame_ok      <= ok;
			out_word_q.op_code       <= ok ? op_n : 8'h00;
			out_word_q.request_tag   <= ok ? tag_n : 16'h0000;
			out_word_q.payload_bytes <= ok ? len_n : 32'h0000_0000;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_word_q;

	// Checks
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		acc && bytes.data.last_byte |=> count_q == '0 && good_q)
		else $error("frame state not cleared after last word");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !bytes.data.last_byte |=>
			(count_q == $past(count_q) + count_t'(1)) || (count_q == COUNT_TOP))
		else $error("byte counter did not advance");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(acc && bytes.data.last_byte))
		else $error("result word without a last byte");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_word_q.frame_ok |->
			out_word_q.op_code == 8'h00 && out_word_q.request_tag == 16'h0000 &&
			out_word_q.payload_bytes == 32'h0000_0000)
		else $error("bad frame result carries nonzero fields");

endmodule
